// ===== rtl/ucd_pkg.sv =====
package ucd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 16;

  typedef enum logic [0:0] {
    CFG_FINAL_TAG = 1'b0,
    CFG_CHUNK_TAG = 1'b1
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] FINAL_TAG_RST = 8'h53;
  localparam logic [BYTE_W-1:0] CHUNK_TAG_RST = 8'h73;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_req;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              end_of_string;
    logic              bad_tag;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_req;
    logic              is_chunk;
    logic              is_final;
    logic [1:0]        cont_cnt;
  } cls_item_t;

  function automatic logic [1:0] lead_cont(input logic [BYTE_W-1:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      n = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      n = 2'd2;
    end else if ((b & LEAD3_MASK) == LEAD4_CODE) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// ===== rtl/ucd_front.sv =====
module ucd_front import ucd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  cfg_idx_t          wr_index,
  input  logic [BYTE_W-1:0] wr_data,
  input  in_item_t          item,
  input  logic              item_valid,
  output logic              item_ready,
  output cls_item_t         head,
  output logic              head_valid,
  input  logic              head_pop
);

  logic [BYTE_W-1:0] final_tag;
  logic [BYTE_W-1:0] link_tag;
  cls_item_t         queue [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;
  cls_item_t         cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      final_tag <= FINAL_TAG_RST;
      link_tag  <= CHUNK_TAG_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_FINAL_TAG: final_tag <= wr_data;
        CFG_CHUNK_TAG: link_tag  <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls.data_byte = item.data_byte;
    cls.start_req = item.start_req;
    cls.is_chunk  = (item.data_byte == link_tag);
    cls.is_final  = (item.data_byte == final_tag);
    cls.cont_cnt  = lead_cont(item.data_byte);
  end

  assign item_ready = (count != 2'd2);
  assign push       = item_valid && item_ready;
  assign head_valid = (count != 2'd0);
  assign pop        = head_pop && head_valid;
  assign head       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ucd_back.sv =====
module ucd_back import ucd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cls_item_t head,
  input  logic      head_valid,
  output logic      head_pop,
  output out_item_t result,
  output logic      result_valid,
  input  logic      result_ready
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_LEAD   = 6'b001000,
    PH_CONT   = 6'b010000,
    PH_TAG    = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  chars_left, chars_left_next;
  logic [1:0]        cont_left, cont_left_next;
  logic              seg_chunk, seg_chunk_next;
  logic [BYTE_W-1:0] length_high, length_high_next;
  logic              emit;
  out_item_t         res;
  logic [CNT_W-1:0]  chars_dec;
  logic [1:0]        cont_dec;

  assign head_pop  = head_valid && (!result_valid || result_ready);
  assign chars_dec = chars_left - CNT_W'(1);
  assign cont_dec  = cont_left - 2'd1;

  always_comb begin
    phase_next       = phase;
    chars_left_next  = chars_left;
    cont_left_next   = cont_left;
    seg_chunk_next   = seg_chunk;
    length_high_next = length_high;
    emit             = 1'b0;
    res              = '0;
    if (head.start_req) begin
      chars_left_next  = '0;
      cont_left_next   = 2'd0;
      length_high_next = '0;
      if (head.is_chunk) begin
        seg_chunk_next = 1'b1;
        phase_next     = PH_LEN_HI;
      end else if (head.is_final) begin
        seg_chunk_next = 1'b0;
        phase_next     = PH_LEN_HI;
      end else begin
        seg_chunk_next = 1'b0;
        phase_next     = PH_IDLE;
        emit           = 1'b1;
        res.bad_tag    = 1'b1;
      end
    end else begin
      case (phase)
        PH_LEN_HI: begin
          length_high_next = head.data_byte;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          chars_left_next = {length_high, head.data_byte};
          if ({length_high, head.data_byte} != '0) begin
            phase_next = PH_LEAD;
          end else if (seg_chunk) begin
            phase_next = PH_TAG;
          end else begin
            phase_next        = PH_IDLE;
            emit              = 1'b1;
            res.end_of_string = 1'b1;
          end
        end
        PH_LEAD: begin
          chars_left_next   = chars_dec;
          cont_left_next    = head.cont_cnt;
          emit              = 1'b1;
          res.payload_byte  = head.data_byte;
          res.payload_valid = 1'b1;
          if (head.cont_cnt != 2'd0) begin
            phase_next = PH_CONT;
          end else if (chars_dec == '0) begin
            res.end_of_string = !seg_chunk;
            phase_next        = seg_chunk ? PH_TAG : PH_IDLE;
          end
        end
        PH_CONT: begin
          cont_left_next    = cont_dec;
          emit              = 1'b1;
          res.payload_byte  = head.data_byte;
          res.payload_valid = 1'b1;
          if (cont_dec == 2'd0) begin
            if (chars_left != '0) begin
              phase_next = PH_LEAD;
            end else begin
              res.end_of_string = !seg_chunk;
              phase_next        = seg_chunk ? PH_TAG : PH_IDLE;
            end
          end
        end
        PH_TAG: begin
          seg_chunk_next = head.is_chunk;
          phase_next     = PH_LEN_HI;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      chars_left   <= '0;
      cont_left    <= 2'd0;
      seg_chunk    <= 1'b0;
      length_high  <= '0;
      result_valid <= 1'b0;
    end else if (head_pop) begin
      phase        <= phase_next;
      chars_left   <= chars_left_next;
      cont_left    <= cont_left_next;
      seg_chunk    <= seg_chunk_next;
      length_high  <= length_high_next;
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && emit) begin
      result <= res;
    end
  end

endmodule

// ===== rtl/utf8_chunk_deframer_top.sv =====
// channel   direction  handshake                   payload
// item      in         item_valid / item_ready     in_item_t  (data_byte, start_req)
// result    out        result_valid / result_ready out_item_t (payload_byte, payload_valid,
//                                                              end_of_string, bad_tag)
// config    in         wr_en                       wr_index, wr_data
//
// One byte per clock sustained while result_ready stays high; a byte is registered in the
// queue, then its result in the result register (classify and queue, then the parser).
// A two-entry queue separates tag classification from the parser, so input is taken while
// a result waits. rst is synchronous: tags return to 'S' and 's', the queue empties and the
// parser goes idle. Header bytes give no result, save a bad tag or an empty final length.
module utf8_chunk_deframer_top import ucd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  cfg_idx_t          wr_index,
  input  logic [BYTE_W-1:0] wr_data,
  input  in_item_t          item,
  input  logic              item_valid,
  output logic              item_ready,
  output out_item_t         result,
  output logic              result_valid,
  input  logic              result_ready
);

  cls_item_t head;
  logic      head_valid;
  logic      head_pop;

  ucd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  ucd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_pop     (head_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

`ifndef SYNTHESIS
  a_bad_tag_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_tag |-> !result.payload_valid && !result.end_of_string)
    else $error("bad_tag result carries payload or end flag");

  a_no_stray_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.payload_valid |-> result.payload_byte == '0)
    else $error("payload_byte nonzero without payload_valid");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head_pop |=> head_valid && $stable(head))
    else $error("queued item lost while parser stalled");

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid && (!result_valid || result_ready))
    else $error("parser advanced into an occupied result register");
`endif

endmodule
